// File: rtl/lz_window_copy_mtf_decoder_defines.svh
// ----------------------------------------------------------------------------
// LZ window copy decoder assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LZ_WINDOW_COPY_MTF_DECODER_DEFINES_SVH
`define LZ_WINDOW_COPY_MTF_DECODER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define LZWCM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LZWCM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Condition must never hold.
`define LZWCM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// File: rtl/lzwcm_pkg.sv
// ----------------------------------------------------------------------------
// LZ window copy decoder package
// Field widths, stream packing offsets, sequencer states and result beat type.
// ----------------------------------------------------------------------------
package lzwcm_pkg;

  localparam int MtfW     = 8;
  localparam int MtfDepth = 256;
  localparam int PosInW   = 17;
  localparam int LenW     = 7;
  localparam int PosBitsW = 5;

  // input tdata: mtf_index, match_pos, match_len from bit 0 up
  localparam int MtfLsb  = 0;
  localparam int PosLsb  = MtfLsb + MtfW;
  localparam int LenLsb  = PosLsb + PosInW;
  localparam int InDataW = 32;

  // output tdata: out_byte, pos_bits from bit 0 up, zero padded
  localparam int OutDataW = 16;
  localparam int OutPadW  = OutDataW - MtfW - PosBitsW;

  localparam int OutFifoDepth = 4;
  localparam int OutPtrW      = 2;
  localparam int OutCntW      = 3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GROW,
    ST_LIT_HEAD,
    ST_LIT_FETCH,
    ST_LIT_SHIFT,
    ST_LIT_FRONT,
    ST_M_READ,
    ST_M_WAIT,
    ST_M_COPY,
    ST_M_FLUSH
  } dec_state_e;

  typedef struct packed {
    logic [MtfW-1:0]     out_byte;
    logic                last_byte;
    logic [PosBitsW-1:0] pos_bits;
  } out_item_t;

endpackage

// File: rtl/lzwcm_ram.sv
// ----------------------------------------------------------------------------
// LZ window copy decoder RAM
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lzwcm_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/lzwcm_out_fifo.sv
// ----------------------------------------------------------------------------
// LZ window copy decoder output queue
// Small register queue that holds result beats until the sink takes them.
// ----------------------------------------------------------------------------
module lzwcm_out_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  lzwcm_pkg::out_item_t            item_i,
  output logic [lzwcm_pkg::OutCntW-1:0]   count_o,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [lzwcm_pkg::OutDataW-1:0]  m_axis_tdata_o,  // out_byte, pos_bits, pad
  output logic                            m_axis_tlast_o   // last_byte
);

  import lzwcm_pkg::*;

  out_item_t            mem_q [OutFifoDepth];
  out_item_t            head;
  logic [OutPtrW-1:0]   wr_q, rd_q;
  logic [OutCntW-1:0]   cnt_q, cnt_d;
  logic                 pop;

  assign pop   = m_axis_tvalid_o && m_axis_tready_i;
  assign cnt_d = cnt_q + OutCntW'(push_i) - OutCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + OutPtrW'(1);
      end
      if (pop) begin
        rd_q <= rd_q + OutPtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assign head            = mem_q[rd_q];
  assign count_o         = cnt_q;
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = {{OutPadW{1'b0}}, head.pos_bits, head.out_byte};
  assign m_axis_tlast_o  = head.last_byte;

endmodule

// File: rtl/lz_window_copy_mtf_decoder.sv
// ----------------------------------------------------------------------------
// LZ window copy decoder with move-to-front literals
// Token back end of an LZSS decoder: expands literal and match tokens into
// output bytes through a sliding window memory.
// ----------------------------------------------------------------------------
// One token is taken at a time; s_axis_tready_o is high only while the block
// is between tokens. For a literal token, its byte is looked up in a
// 256-entry move-to-front memory and the entries ahead of it are shifted
// down one per cycle through that memory's single write port before the
// byte goes to the front. For a match token of length n, n window reads
// fill a staging memory, then n staging reads write the window at the write
// pointer and emit one beat each, so an overlapping copy sees the window as
// it was before the token. A match of length zero emits nothing. Every beat
// carries the position width after its token's growth check; the width
// grows by one when the write pointer lands exactly on 2^width, up to
// WINDOW_BITS. Window entries never written since reset read as zero
// (tracked by the write pointer and a wrap flag), so no clearing pass is
// needed after reset. A four-beat output queue lets the block keep working
// while the sink stalls.
// ----------------------------------------------------------------------------
`include "lz_window_copy_mtf_decoder_defines.svh"

module lz_window_copy_mtf_decoder #(
  parameter int WINDOW_BITS    = 17,
  parameter int MAX_MATCH      = 64,
  parameter int START_POS_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [lzwcm_pkg::InDataW-1:0]   s_axis_tdata_i,  // mtf_index, match_pos, match_len
  input  logic                            s_axis_tuser_i,  // req_type
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [lzwcm_pkg::OutDataW-1:0]  m_axis_tdata_o,  // out_byte, pos_bits, pad
  output logic                            m_axis_tlast_o   // last_byte
);

  import lzwcm_pkg::*;

  localparam int WinDepth = 1 << WINDOW_BITS;
  localparam int StW      = $clog2(MAX_MATCH);
  localparam int CntW     = $clog2(MAX_MATCH + 1);
  localparam logic [WINDOW_BITS-1:0] PtrOne = 1;

  // Sequencer and token registers
  dec_state_e               state_q, state_d;
  logic                     req_lit_q;
  logic [MtfW-1:0]          idx_q;
  logic [WINDOW_BITS-1:0]   src_q;
  logic [CntW-1:0]          n_q;
  logic [StW-1:0]           rd_cnt_q;
  logic [MtfW-1:0]          byte_q;

  // Window fill tracking and position width
  logic [WINDOW_BITS-1:0]   wptr_q;
  logic                     wrapped_q;
  logic [PosBitsW-1:0]      pos_width_q;

  // Move-to-front memory read tracking
  logic [MtfDepth-1:0]      mtf_vld_q;
  logic                     mtf_rvld_q;
  logic [MtfW-1:0]          mtf_raddr_q;

  // Read returns in flight
  logic                     win_pend_q;
  logic [StW-1:0]           win_pend_idx_q;
  logic                     win_known_q;
  logic                     st_pend_q;
  logic                     st_last_q;

  // Memory ports
  logic                     mtf_re, mtf_we;
  logic [MtfW-1:0]          mtf_raddr, mtf_waddr, mtf_wdata, mtf_rdata, mtf_byte;
  logic                     win_re, win_we;
  logic [WINDOW_BITS-1:0]   win_raddr;
  logic [MtfW-1:0]          win_wdata, win_rdata, win_byte;
  logic                     st_issue;
  logic [MtfW-1:0]          st_rdata;

  // Misc control
  logic                     in_accept;
  logic                     lit_commit;
  logic                     room;
  logic [CntW-1:0]          n_m1, n_match;
  logic [StW-1:0]           last_idx;
  logic [WINDOW_BITS-1:0]   end_ptr;
  logic                     grow;
  logic [LenW-1:0]          in_len;
  logic                     fifo_push;
  out_item_t                push_item;
  logic [OutCntW-1:0]       fifo_cnt;

  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  // Clamp the match length to the staging depth
  assign in_len  = s_axis_tdata_i[LenLsb +: LenW];
  assign n_match = (in_len > LenW'(MAX_MATCH)) ? CntW'(MAX_MATCH) : CntW'(in_len);

  assign n_m1     = n_q - CntW'(1);
  assign last_idx = n_m1[StW-1:0];

  // Growth check on the pointer this token ends at
  assign end_ptr = wptr_q + WINDOW_BITS'(n_q);
  assign grow    = (pos_width_q < PosBitsW'(WINDOW_BITS)) && (end_ptr == (PtrOne << pos_width_q));

  // Unwritten move-to-front entries read as their own index, unwritten window
  // entries as zero
  assign mtf_byte = mtf_rvld_q ? mtf_rdata : mtf_raddr_q;
  assign win_byte = win_known_q ? win_rdata : '0;

  assign win_raddr = src_q + WINDOW_BITS'(rd_cnt_q);

  // Leave a slot for the staging read already in flight
  assign room = (fifo_cnt + OutCntW'(st_pend_q)) < OutCntW'(OutFifoDepth);

  // Window writes and result beats come from staging returns or a literal
  assign win_we    = st_pend_q || lit_commit;
  assign win_wdata = st_pend_q ? st_rdata : byte_q;
  assign fifo_push = win_we;

  always_comb begin
    push_item.out_byte  = win_wdata;
    push_item.last_byte = st_pend_q ? st_last_q : 1'b1;
    push_item.pos_bits  = pos_width_q;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_GROW;
      end
      ST_GROW: begin
        if (req_lit_q) begin
          state_d = ST_LIT_HEAD;
        end else if (n_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_M_READ;
        end
      end
      ST_LIT_HEAD: state_d = ST_LIT_FETCH;
      ST_LIT_FETCH: begin
        state_d = (idx_q == '0) ? ST_LIT_FRONT : ST_LIT_SHIFT;
      end
      ST_LIT_SHIFT: begin
        if (idx_q == MtfW'(1)) state_d = ST_LIT_FRONT;
      end
      ST_LIT_FRONT: begin
        if (lit_commit) state_d = ST_IDLE;
      end
      ST_M_READ: begin
        if (rd_cnt_q == last_idx) state_d = ST_M_WAIT;
      end
      ST_M_WAIT: state_d = ST_M_COPY;
      ST_M_COPY: begin
        if (st_issue && (rd_cnt_q == last_idx)) state_d = ST_M_FLUSH;
      end
      ST_M_FLUSH: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Memory strobes per state
  always_comb begin
    mtf_re     = 1'b0;
    mtf_raddr  = idx_q;
    mtf_we     = 1'b0;
    mtf_waddr  = idx_q;
    mtf_wdata  = mtf_byte;
    lit_commit = 1'b0;
    win_re     = 1'b0;
    st_issue   = 1'b0;
    case (state_q)
      ST_LIT_HEAD: begin
        mtf_re = 1'b1;
      end
      ST_LIT_FETCH: begin
        // prefetch the neighbor that shifts into the head's slot
        mtf_re    = (idx_q != '0);
        mtf_raddr = idx_q - MtfW'(1);
      end
      ST_LIT_SHIFT: begin
        // move one entry down, fetch the next one above the front
        mtf_we    = 1'b1;
        mtf_re    = (idx_q != MtfW'(1));
        mtf_raddr = idx_q - MtfW'(2);
      end
      ST_LIT_FRONT: begin
        lit_commit = (fifo_cnt != OutCntW'(OutFifoDepth));
        mtf_we     = lit_commit;
        mtf_waddr  = '0;
        mtf_wdata  = byte_q;
      end
      ST_M_READ: begin
        win_re = 1'b1;
      end
      ST_M_COPY: begin
        st_issue = room;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wptr_q      <= '0;
      wrapped_q   <= 1'b0;
      pos_width_q <= PosBitsW'(START_POS_BITS);
      mtf_vld_q   <= '0;
      win_pend_q  <= 1'b0;
      st_pend_q   <= 1'b0;
      rd_cnt_q    <= '0;
    end else begin
      state_q    <= state_d;
      win_pend_q <= win_re;
      st_pend_q  <= st_issue;
      if (mtf_we) begin
        mtf_vld_q[mtf_waddr] <= 1'b1;
      end
      if (win_we) begin
        wptr_q <= wptr_q + PtrOne;
        if (wptr_q == '1) wrapped_q <= 1'b1;
      end
      if ((state_q == ST_GROW) && grow) begin
        pos_width_q <= pos_width_q + PosBitsW'(1);
      end
      if ((state_q == ST_GROW) || (state_q == ST_M_WAIT)) begin
        rd_cnt_q <= '0;
      end else if (win_re || st_issue) begin
        rd_cnt_q <= rd_cnt_q + StW'(1);
      end
    end
  end

  // Token and read-return payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_lit_q <= !s_axis_tuser_i;
      idx_q     <= s_axis_tdata_i[MtfLsb +: MtfW];
      src_q     <= WINDOW_BITS'(s_axis_tdata_i[PosLsb +: PosInW]);
      n_q       <= s_axis_tuser_i ? n_match : CntW'(1);
    end else if (state_q == ST_LIT_SHIFT) begin
      idx_q <= idx_q - MtfW'(1);
    end
    if (state_q == ST_LIT_FETCH) begin
      byte_q <= mtf_byte;
    end
    if (mtf_re) begin
      mtf_rvld_q  <= mtf_vld_q[mtf_raddr];
      mtf_raddr_q <= mtf_raddr;
    end
    if (win_re) begin
      win_pend_idx_q <= rd_cnt_q;
      win_known_q    <= wrapped_q || (win_raddr < wptr_q);
    end
    if (st_issue) begin
      st_last_q <= (rd_cnt_q == last_idx);
    end
  end

  lzwcm_ram #(
    .Width(MtfW),
    .Depth(MtfDepth)
  ) u_mtf_ram (
    .clk_i  (clk_i),
    .we_i   (mtf_we),
    .waddr_i(mtf_waddr),
    .wdata_i(mtf_wdata),
    .re_i   (mtf_re),
    .raddr_i(mtf_raddr),
    .rdata_o(mtf_rdata)
  );

  lzwcm_ram #(
    .Width(MtfW),
    .Depth(WinDepth)
  ) u_win_ram (
    .clk_i  (clk_i),
    .we_i   (win_we),
    .waddr_i(wptr_q),
    .wdata_i(win_wdata),
    .re_i   (win_re),
    .raddr_i(win_raddr),
    .rdata_o(win_rdata)
  );

  // Staging memory: filled from window reads, drained into the window
  lzwcm_ram #(
    .Width(MtfW),
    .Depth(MAX_MATCH)
  ) u_stage_ram (
    .clk_i  (clk_i),
    .we_i   (win_pend_q),
    .waddr_i(win_pend_idx_q),
    .wdata_i(win_byte),
    .re_i   (st_issue),
    .raddr_i(rd_cnt_q),
    .rdata_o(st_rdata)
  );

  lzwcm_out_fifo u_out_fifo (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (fifo_push),
    .item_i         (push_item),
    .count_o        (fifo_cnt),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  `LZWCM_ASSERT_IMP(a_no_overflow, fifo_push, fifo_cnt != OutCntW'(OutFifoDepth), "output queue overflow")
  `LZWCM_ASSERT_NEVER(a_win_phase, win_re && win_we, "window read and write overlap")
  `LZWCM_ASSERT_IMP(a_mtf_addr, mtf_re && mtf_we, mtf_raddr != mtf_waddr, "move-to-front port collision")
  `LZWCM_ASSERT_IMP(a_accept_quiet, in_accept, !st_pend_q && !win_pend_q, "token taken with reads in flight")
  `LZWCM_ASSERT_NXT(a_stage_beat, st_issue, fifo_push && win_we, "staging read did not produce a beat")

endmodule
